/* hdl/twcr_pkg.sv */
// ----------------------------------------------------------------------------
// Textured wall column renderer package
// Shared codes and types for the column renderer and its checker.
// ----------------------------------------------------------------------------
package twcr_pkg;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   localparam logic [1:0] CSR_CEILING = 2'd0;
   localparam logic [1:0] CSR_FLOOR   = 2'd1;
   localparam logic [1:0] CSR_PITCH   = 2'd2;

   localparam logic [1:0] TEX_EAST  = 2'd0;
   localparam logic [1:0] TEX_WEST  = 2'd1;
   localparam logic [1:0] TEX_SOUTH = 2'd2;
   localparam logic [1:0] TEX_NORTH = 2'd3;

   localparam int COLUMN_W = 10;
   localparam int OUT_ROW_W = 6;
   localparam int COLOR_W = 32;
   localparam int DIST_W = 16;
   localparam int SPAN_W = 8;
   localparam int GEOM_W = 11;

   typedef enum logic [1:0] {
      REGION_CEILING = 2'd0,
      REGION_WALL    = 2'd1,
      REGION_FLOOR   = 2'd2
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_HGT,
      ST_DIV_STEP,
      ST_GEOM,
      ST_ROWS
   } state_type;

   typedef struct packed {
      logic [COLUMN_W-1:0]  column;
      logic [OUT_ROW_W-1:0] row;
      region_type           region;
      logic                 drawn;
      logic                 last;
   } row_info_type;

endpackage

/* hdl/twcr_div.sv */
// ----------------------------------------------------------------------------
// Column renderer divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module twcr_div #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0] rem_shift;
   logic [DIVISOR_W:0] diff;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff      = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/textured_wall_column_renderer_top.sv */
// ----------------------------------------------------------------------------
// Textured wall column renderer
// Four wall textures in one synchronous memory; renders one screen column
// per render request, top row first.
// ----------------------------------------------------------------------------
// A load request writes one texel when its index is in range and produces
// no response. A render request runs two serial divisions (wall height,
// then texture step), then the ST_GEOM setup state, then issues one row per
// cycle into the texture memory read port while the response side accepts
// rows. The next request is taken as soon as the last row is issued, while
// earlier rows still drain.
// ----------------------------------------------------------------------------
module textured_wall_column_renderer_top #(
   parameter int SCREEN_ROWS = 64,
   parameter int TEX_WIDTH   = 64,
   parameter int TEX_HEIGHT  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // texture_sel, texel_index, texel_rgba, hit_side, dir_x_positive,
   // dir_y_positive, hit_fraction, wall_distance, screen_column, zero pad
   input  logic [95:0] req_tdata,
   // req_type
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_column, out_row, pixel_color
   output logic [47:0] rsp_tdata,
   // region, drawn
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int TEX_SIZE  = TEX_WIDTH * TEX_HEIGHT;
   localparam int TEX_DEPTH = 4 * TEX_SIZE;
   localparam int ADDR_W    = $clog2(TEX_DEPTH);
   localparam int TC_W      = $clog2(TEX_WIDTH);
   localparam int TR_W      = $clog2(TEX_HEIGHT);
   localparam int ROW_W     = $clog2(SCREEN_ROWS);
   localparam int HGT_MAX   = 4 * SCREEN_ROWS;
   localparam int HGT_W     = $clog2(HGT_MAX + 1);
   localparam int DIV_W     = $clog2(TEX_HEIGHT * 65536 + 1);
   localparam int PROD_W    = DIV_W + 10;

   localparam int GW = twcr_pkg::GEOM_W;
   localparam int SW = twcr_pkg::SPAN_W;
   localparam int CW = twcr_pkg::COLOR_W;

   // request fields
   logic [1:0]                   req_sel;
   logic [11:0]                  req_idx;
   logic [CW-1:0]                req_rgba;
   logic                         req_side;
   logic                         req_dxp;
   logic                         req_dyp;
   logic [15:0]                  req_frac;
   logic [twcr_pkg::DIST_W-1:0]  req_dist;
   logic [twcr_pkg::COLUMN_W-1:0] req_col;

   assign req_sel  = req_tdata[1:0];
   assign req_idx  = req_tdata[13:2];
   assign req_rgba = req_tdata[45:14];
   assign req_side = req_tdata[46];
   assign req_dxp  = req_tdata[47];
   assign req_dyp  = req_tdata[48];
   assign req_frac = req_tdata[64:49];
   assign req_dist = req_tdata[80:65];
   assign req_col  = req_tdata[90:81];

   twcr_pkg::state_type state_ff, state_in;

   logic [CW-1:0] ceiling_ff, ceiling_in;
   logic [CW-1:0] floor_ff, floor_in;
   logic [7:0]    pitch_ff, pitch_in;

   logic [1:0]                    tex_ff, tex_in;
   logic [TC_W-1:0]               tcol_ff, tcol_in;
   logic [twcr_pkg::COLUMN_W-1:0] column_ff, column_in;
   logic [HGT_W-1:0]              height_ff, height_in;
   logic [DIV_W-1:0]              step_ff, step_in;
   logic [31:0]                   pos_ff, pos_in;
   logic [SW-1:0]                 start_ff, start_in;
   logic [SW-1:0]                 end_ff, end_in;
   logic [ROW_W-1:0]              row_ff, row_in;

   logic                       s1_valid_ff, s1_valid_in;
   twcr_pkg::row_info_type     s1_info_ff, s1_info_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   twcr_pkg::row_info_type     rsp_info_ff, rsp_info_in;
   logic [CW-1:0]              rsp_color_ff, rsp_color_in;
   logic [CW-1:0]              rd_data_ff;

   logic [CW-1:0] tex_mem [TEX_DEPTH];

   // control
   logic             req_accept;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [15:0]      div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_q;
   logic             s1_adv;
   logic             issue;
   logic             issue_last;

   // datapath
   logic              load_ok;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [23:0]       frac_prod;
   logic [TC_W-1:0]   tcol_raw;
   logic [HGT_W-1:0]  height_sat;
   logic [GW-1:0]     pitch_x2;
   logic [GW-1:0]     v2;
   logic [GW-1:0]     start_s;
   logic [GW-1:0]     neg_s;
   logic [GW-1:0]     end_s;
   logic [PROD_W-1:0] prod;
   logic [63:0]       prod_ext;
   logic [31:0]       pos_sat;
   logic [SW-1:0]     y_ext;
   logic              is_ceil;
   logic              is_floor;
   logic              row_in_tex;
   logic [TR_W-1:0]   trow;
   logic [32:0]       pos_sum;

   assign req_accept = req_tvalid && req_tready;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign issue_last = row_ff == ROW_W'(SCREEN_ROWS - 1);

   twcr_div #(
      .DIVIDEND_W(DIV_W),
      .DIVISOR_W (16)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      height_sat = (div_q > DIV_W'(HGT_MAX)) ? HGT_W'(HGT_MAX) : div_q[HGT_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twcr_pkg::ST_IDLE: begin
            if (req_accept && req_tuser[0] == twcr_pkg::REQ_RENDER) begin
               state_in = twcr_pkg::ST_DIV_HGT;
            end
         end
         twcr_pkg::ST_DIV_HGT: begin
            if (div_done) begin
               state_in = twcr_pkg::ST_DIV_STEP;
            end
         end
         twcr_pkg::ST_DIV_STEP: begin
            if (div_done) begin
               state_in = twcr_pkg::ST_GEOM;
            end
         end
         twcr_pkg::ST_GEOM: begin
            state_in = twcr_pkg::ST_ROWS;
         end
         twcr_pkg::ST_ROWS: begin
            if (issue && issue_last) begin
               state_in = twcr_pkg::ST_IDLE;
            end
         end
         default: state_in = twcr_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_W'(SCREEN_ROWS * 256);
      div_divisor  = req_dist;
      issue        = 1'b0;
      unique case (state_ff)
         twcr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid && req_tuser[0] == twcr_pkg::REQ_RENDER;
         end
         twcr_pkg::ST_DIV_HGT: begin
            div_start    = div_done;
            div_dividend = DIV_W'(TEX_HEIGHT * 65536);
            div_divisor  = 16'(height_sat);
         end
         twcr_pkg::ST_DIV_STEP: begin
            div_dividend = DIV_W'(TEX_HEIGHT * 65536);
            div_divisor  = 16'(height_ff);
         end
         twcr_pkg::ST_GEOM: begin
         end
         twcr_pkg::ST_ROWS: begin
            issue = !s1_valid_ff || s1_adv;
         end
         default: begin
         end
      endcase
   end

   // configuration
   always_comb begin
      ceiling_in = ceiling_ff;
      floor_in   = floor_ff;
      pitch_in   = pitch_ff;
      if (csr_we) begin
         unique case (csr_addr)
            twcr_pkg::CSR_CEILING: ceiling_in = csr_wdata;
            twcr_pkg::CSR_FLOOR:   floor_in   = csr_wdata;
            twcr_pkg::CSR_PITCH:   pitch_in   = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // texel load
   always_comb begin
      load_ok   = 32'(req_idx) < 32'(TEX_SIZE);
      mem_we    = req_accept && req_tuser[0] == twcr_pkg::REQ_LOAD && load_ok;
      mem_waddr = ADDR_W'(32'(req_sel) * 32'(TEX_SIZE)) + ADDR_W'(req_idx);
   end

   // column setup on accept
   always_comb begin
      frac_prod = 24'(req_frac) * 24'(TEX_WIDTH);
      tcol_raw  = frac_prod[16 +: TC_W];
      tex_in    = tex_ff;
      tcol_in   = tcol_ff;
      column_in = column_ff;
      if (req_accept && req_tuser[0] == twcr_pkg::REQ_RENDER) begin
         column_in = req_col;
         if (!req_side) begin
            tex_in  = req_dxp ? twcr_pkg::TEX_EAST : twcr_pkg::TEX_WEST;
            tcol_in = tcol_raw;
         end else begin
            tex_in  = req_dyp ? twcr_pkg::TEX_SOUTH : twcr_pkg::TEX_NORTH;
            tcol_in = req_dyp ? TC_W'(TEX_WIDTH - 1) - tcol_raw : tcol_raw;
         end
      end
   end

   // height, step and span geometry
   always_comb begin
      pitch_x2 = {{2{pitch_ff[7]}}, pitch_ff, 1'b0};
      v2       = GW'(SCREEN_ROWS) - GW'(height_ff) + pitch_x2;
      start_s  = {v2[GW-1], v2[GW-1:1]} + GW'(v2[GW-1] & v2[0]);
      neg_s    = GW'(0) - start_s;
      end_s    = start_s + GW'(height_ff);
      prod     = PROD_W'(neg_s[9:0]) * PROD_W'(step_ff);
      prod_ext = 64'(prod);
      pos_sat  = (prod_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod_ext[31:0];

      height_in = height_ff;
      step_in   = step_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      if (state_ff == twcr_pkg::ST_DIV_HGT && div_done) begin
         height_in = height_sat;
      end
      if (state_ff == twcr_pkg::ST_DIV_STEP && div_done) begin
         step_in = (height_ff == '0) ? '0 : div_q;
      end
      if (state_ff == twcr_pkg::ST_GEOM) begin
         start_in = start_s[GW-1] ? '0 : start_s[SW-1:0];
         if (end_s[GW-1]) begin
            end_in = '0;
         end else if (end_s > GW'(SCREEN_ROWS)) begin
            end_in = SW'(SCREEN_ROWS);
         end else begin
            end_in = end_s[SW-1:0];
         end
      end
   end

   // row issue
   always_comb begin
      y_ext      = SW'(row_ff);
      is_ceil    = y_ext < start_ff;
      is_floor   = !is_ceil && y_ext >= end_ff;
      row_in_tex = pos_ff[31:16] < 16'(TEX_HEIGHT);
      trow       = pos_ff[16 +: TR_W];
      pos_sum    = {1'b0, pos_ff} + 33'(step_ff);
      mem_re     = issue && !is_ceil && !is_floor && row_in_tex;
      mem_raddr  = ADDR_W'(32'(tex_ff) * 32'(TEX_SIZE))
                 + ADDR_W'(32'(trow) * 32'(TEX_WIDTH)) + ADDR_W'(tcol_ff);

      pos_in = pos_ff;
      row_in = row_ff;
      if (state_ff == twcr_pkg::ST_GEOM) begin
         pos_in = start_s[GW-1] ? pos_sat : '0;
         row_in = '0;
      end else if (issue) begin
         row_in = row_ff + 1'b1;
         if (!is_ceil && !is_floor) begin
            pos_in = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
         end
      end

      s1_info_in.column = column_ff;
      s1_info_in.row    = twcr_pkg::OUT_ROW_W'(row_ff);
      s1_info_in.region = is_ceil  ? twcr_pkg::REGION_CEILING :
                          is_floor ? twcr_pkg::REGION_FLOOR : twcr_pkg::REGION_WALL;
      s1_info_in.drawn  = is_ceil || is_floor || row_in_tex;
      s1_info_in.last   = issue_last;
      if (!issue) begin
         s1_info_in = s1_info_ff;
      end
      s1_valid_in = issue || (s1_valid_ff && !s1_adv);
   end

   // response register
   always_comb begin
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);
      rsp_info_in  = rsp_info_ff;
      rsp_color_in = rsp_color_ff;
      if (s1_adv) begin
         rsp_info_in = s1_info_ff;
         case (s1_info_ff.region)
            twcr_pkg::REGION_CEILING: rsp_color_in = ceiling_ff;
            twcr_pkg::REGION_FLOOR:   rsp_color_in = floor_ff;
            default:                  rsp_color_in = s1_info_ff.drawn ? rd_data_ff : '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tex_mem[mem_waddr] <= req_rgba;
      end
      if (mem_re) begin
         rd_data_ff <= tex_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twcr_pkg::ST_IDLE;
         ceiling_ff   <= '0;
         floor_ff     <= '0;
         pitch_ff     <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         step_ff      <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ceiling_ff   <= ceiling_in;
         floor_ff     <= floor_in;
         pitch_ff     <= pitch_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tex_ff       <= tex_in;
      tcol_ff      <= tcol_in;
      column_ff    <= column_in;
      height_ff    <= height_in;
      s1_info_ff   <= s1_info_in;
      rsp_info_ff  <= rsp_info_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_color_ff, rsp_info_ff.row, rsp_info_ff.column};
   assign rsp_tuser  = {rsp_info_ff.drawn, rsp_info_ff.region};
   assign rsp_tlast  = rsp_info_ff.last;

endmodule

/* hdl/twcr_checker.sv */
// ----------------------------------------------------------------------------
// Column renderer port checker
// Watches the renderer's ports for row order, stall behavior, flags and render busy.
// ----------------------------------------------------------------------------
module twcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic       rsp_accept;
   logic [5:0] exp_row_ff, exp_row_in;

   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      exp_row_in = exp_row_ff;
      if (rsp_accept) begin
         exp_row_in = rsp_tlast ? 6'd0 : rsp_tdata[15:10] + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
      end else begin
         exp_row_ff <= exp_row_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_accept |-> rsp_tdata[15:10] == exp_row_ff)
      else $error("response row out of order");

   a_undrawn_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |->
         rsp_tuser[1:0] == twcr_pkg::REGION_WALL && rsp_tdata[47:16] == 32'd0)
      else $error("undrawn pixel outside wall or with color");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == twcr_pkg::REQ_RENDER |=> !req_tready)
      else $error("request taken during column setup");

endmodule

bind textured_wall_column_renderer_top twcr_checker u_twcr_checker (.*);
